// File: design/ip_mask_filter_table_defines.svh
// ---------------------------------------------------------------------------
// IP mask filter table: assertion macros
// Shared assertion helpers, clocked on i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef IP_MASK_FILTER_TABLE_DEFINES_SVH
`define IP_MASK_FILTER_TABLE_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define IMFT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("imft assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define IMFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("imft assertion failed");

`endif

// File: design/imft_pkg.sv
// ---------------------------------------------------------------------------
// IP mask filter table: package
// Table depth, operation and status codes, the token that travels along the
// cell chain and the octet mask function.
// ---------------------------------------------------------------------------
package imft_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = 32;
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

    // One command in flight along the chain of cells.
    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] address;
        logic              hit;
        logic              claimed;
    } t_token;

    // Each nonzero octet of a filter compares in full; a zero octet is a wildcard.
    function automatic logic [ADDR_W-1:0] octet_mask(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] m;
        m = '0;
        for (int k = 0; k < ADDR_W / 8; k++) begin
            if (a[8*k +: 8] != 8'd0) begin
                m[8*k +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// File: design/imft_req_if.sv
// ---------------------------------------------------------------------------
// IP mask filter table: request channel
// Carries one command (opcode and address) per transaction.
// ---------------------------------------------------------------------------
interface imft_req_if;
    import imft_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output opcode, output address, input ready);
    modport sink   (input valid, input opcode, input address, output ready);
endinterface

// File: design/imft_resp_if.sv
// ---------------------------------------------------------------------------
// IP mask filter table: response channel
// Carries one result (rejected flag and status) per transaction.
// ---------------------------------------------------------------------------
interface imft_resp_if;
    import imft_pkg::*;

    logic            valid;
    logic            ready;
    logic            rejected;
    logic [ST_W-1:0] status;

    modport source (output valid, output rejected, output status, input ready);
    modport sink   (input valid, input rejected, input status, output ready);
endinterface

// File: design/imft_cfg_if.sv
// ---------------------------------------------------------------------------
// IP mask filter table: configuration channel
// Writes the ban_mode register, one value per transaction.
// ---------------------------------------------------------------------------
interface imft_cfg_if;
    logic valid;
    logic ready;
    logic ban_mode;

    modport source (output valid, output ban_mode, input ready);
    modport sink   (input valid, input ban_mode, output ready);
endinterface

// File: design/imft_cell.sv
// ---------------------------------------------------------------------------
// IP mask filter table: table cell
// Holds one filter entry, acts on the token passing through and hands the
// token to the next cell through its token register.
// ---------------------------------------------------------------------------
`include "ip_mask_filter_table_defines.svh"

module imft_cell
    import imft_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_token i_token,
    output t_token o_token
);

    logic              r_live;
    logic              n_live;
    logic [ADDR_W-1:0] r_addr;
    logic              w_addr_we;
    t_token            r_token;
    t_token            n_token;
    logic              w_match;
    logic              w_equal;
    logic              w_take_add;
    logic              w_take_remove;

    // Masked compare for checks, exact compare for removes.
    assign w_match = r_live && ((i_token.address & octet_mask(r_addr)) == r_addr);
    assign w_equal = r_live && (i_token.address == r_addr);

    // This cell takes an unclaimed add when free, or an unclaimed remove when equal.
    assign w_take_add    = i_token.valid && (i_token.op == OP_ADD) &&
                           !i_token.claimed && !r_live;
    assign w_take_remove = i_token.valid && (i_token.op == OP_REMOVE) &&
                           !i_token.claimed && w_equal;

    // Act on the token: checks record a hit, the first free cell takes an add,
    // the first equal live cell takes a remove.
    always_comb begin
        n_token   = i_token;
        n_live    = r_live;
        w_addr_we = 1'b0;
        if (i_token.valid) begin
            unique case (i_token.op)
                OP_CHECK: begin
                    if (w_match) begin
                        n_token.hit = 1'b1;
                    end
                end
                OP_ADD: begin
                    if (!i_token.claimed && !r_live) begin
                        n_token.claimed = 1'b1;
                        n_live          = 1'b1;
                        w_addr_we       = 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (!i_token.claimed && w_equal) begin
                        n_token.claimed = 1'b1;
                        n_live          = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Live bit and token; only the live bit and the token valid are reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live        <= 1'b0;
            r_token.valid <= 1'b0;
        end else if (i_en) begin
            r_live  <= n_live;
            r_token <= n_token;
        end
    end

    // Stored filter address.
    always_ff @(posedge i_clk) begin
        if (i_en && w_addr_we) begin
            r_addr <= i_token.address;
        end
    end

    assign o_token = r_token;

    // An add taken here leaves the entry live and holding the filter.
    `IMFT_ASSERT_NEXT(a_add_stores, i_en && w_take_add, r_live && r_addr == $past(i_token.address))
    // A remove taken here frees the entry.
    `IMFT_ASSERT_NEXT(a_remove_frees, i_en && w_take_remove, !r_live)
    // Once claimed, a token stays claimed further down the chain.
    `IMFT_ASSERT_NEXT(a_claim_kept, i_en && i_token.valid && i_token.claimed, r_token.claimed)

endmodule

// File: design/ip_mask_filter_table.sv
// ---------------------------------------------------------------------------
// IP mask filter table: top level
// A chain of table cells with a request, a response and a configuration
// channel.
// ---------------------------------------------------------------------------
// Usage:
//   i_req carries commands: check an address, add a filter or remove one.
//   o_resp returns one result per command, in order: rejected and status.
//   i_cfg writes ban_mode; it is always ready and takes effect at once, and
//   should be written only while no command is in flight.
// Flow and throughput:
//   A command walks the chain of TABLE_DEPTH cells, through each cell's token
//   register in turn, and lands in the output register. Each cell sees
//   commands in order, so a new command may be accepted in every cycle while
//   the chain is not stalled: one per cycle sustained.
// Reset:
//   All entries are freed and ban_mode returns to 1 (ban matching addresses).
// Stalls:
//   While a result waits in the output register and o_resp.ready is low,
//   the whole chain holds and i_req.ready is low.
// ---------------------------------------------------------------------------
`include "ip_mask_filter_table_defines.svh"

module ip_mask_filter_table
    import imft_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    imft_req_if.sink    i_req,
    imft_resp_if.source o_resp,
    imft_cfg_if.sink    i_cfg
);

    t_token          w_chain [TABLE_DEPTH+1];
    t_token          w_last;
    logic            w_en;
    logic            r_ban_mode;
    logic            r_out_valid;
    logic            r_rejected;
    logic [ST_W-1:0] r_status;
    logic            n_rejected;
    logic [ST_W-1:0] n_status;

    // The chain moves whenever the output register is empty or being drained.
    assign w_en        = !r_out_valid || o_resp.ready;
    assign i_req.ready = w_en;
    assign i_cfg.ready = 1'b1;

    // Token entering the first cell: valid, opcode, address, no hit, unclaimed.
    assign w_chain[0] = {i_req.valid, i_req.opcode, i_req.address, 1'b0, 1'b0};

    // Row of cells, one per table entry.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        imft_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_token (w_chain[g]),
            .o_token (w_chain[g+1])
        );
    end

    assign w_last = w_chain[TABLE_DEPTH];

    // Result from the token leaving the last cell.
    always_comb begin
        n_rejected = 1'b0;
        n_status   = ST_DONE;
        unique case (w_last.op)
            OP_CHECK: begin
                n_rejected = w_last.hit ? r_ban_mode : !r_ban_mode;
            end
            OP_ADD: begin
                n_status = w_last.claimed ? ST_DONE : ST_FULL;
            end
            OP_REMOVE: begin
                n_status = w_last.claimed ? ST_DONE : ST_NOT_FOUND;
            end
            default: begin
            end
        endcase
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ban_mode <= 1'b1;
        end else if (i_cfg.valid) begin
            r_ban_mode <= i_cfg.ban_mode;
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_last.valid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rejected <= n_rejected;
            r_status   <= n_status;
        end
    end

    assign o_resp.valid    = r_out_valid;
    assign o_resp.rejected = r_rejected;
    assign o_resp.status   = r_status;

    // A token leaving the chain always becomes a pending result.
    `IMFT_ASSERT_NEXT(a_last_to_out, w_en && w_last.valid, r_out_valid)
    // Checks never report a failure status.
    `IMFT_ASSERT_NEXT(a_check_done, w_en && w_last.valid && w_last.op == OP_CHECK, r_status == ST_DONE)
    // Only checks may reject.
    `IMFT_ASSERT_NEXT(a_reject_check, w_en && w_last.valid && w_last.op != OP_CHECK, !r_rejected)

endmodule

// File: tb/sv/ip_mask_filter_table_tb.sv
// ---------------------------------------------------------------------------
// IP mask filter table: testbench
// Drives check, add, remove and spare commands through the request channel under
// random bursts and response stalls. Each accepted command is run through a
// local table model, and every response is compared in order with its result.
// The ban_mode register is flipped between phases once the block has drained.
// ---------------------------------------------------------------------------
module ip_mask_filter_table_tb;
    import imft_pkg::*;

    // Spare opcode, which the block must answer without touching the table.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
    } command_t;

    typedef struct packed {
        logic            rejected;
        logic [ST_W-1:0] status;
    } verdict_t;

    logic i_clk;
    logic i_rst_n;

    imft_req_if  req_if();
    imft_resp_if resp_if();
    imft_cfg_if  cfg_if();

    ip_mask_filter_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_resp  (resp_if),
        .i_cfg   (cfg_if)
    );

    // Commands waiting to be driven, and verdicts waiting for their response.
    command_t command_q[$];
    verdict_t verdict_q[$];

    // Local copy of the filter table and the register.
    logic [ADDR_W-1:0] slot_filter [TABLE_DEPTH];
    logic              slot_live   [TABLE_DEPTH];
    int                high_water = 0;
    logic              ban_mode_copy = 1'b1;

    // Filters the generator believes are stored, used to aim checks and removes.
    logic [ADDR_W-1:0] filter_pool[$];

    int mismatch_count = 0;
    int cycle_count = 0;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Cycle counter with a hard limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // A nonzero octet compares in full; a zero octet matches anything.
    function automatic logic [ADDR_W-1:0] wildcard_mask(input logic [ADDR_W-1:0] f);
        return {{8{|f[31:24]}}, {8{|f[23:16]}}, {8{|f[15:8]}}, {8{|f[7:0]}}};
    endfunction

    // Apply one command to the local table and return the response it must give.
    function automatic verdict_t apply_command(input logic [OP_W-1:0] op,
                                               input logic [ADDR_W-1:0] addr);
        verdict_t v;
        int       slot;
        logic     matched;
        v.rejected = 1'b0;
        v.status   = ST_DONE;
        slot       = -1;
        matched    = 1'b0;
        case (op)
            OP_CHECK: begin
                for (int i = 0; i < high_water; i++) begin
                    if (slot_live[i] &&
                        ((addr & wildcard_mask(slot_filter[i])) == slot_filter[i])) begin
                        matched = 1'b1;
                    end
                end
                v.rejected = matched ? ban_mode_copy : ~ban_mode_copy;
            end
            OP_ADD: begin
                // Lowest free slot below the high-water mark, else append.
                for (int i = high_water - 1; i >= 0; i--) begin
                    if (!slot_live[i]) begin
                        slot = i;
                    end
                end
                if (slot < 0 && high_water < TABLE_DEPTH) begin
                    slot = high_water;
                    high_water++;
                end
                if (slot < 0) begin
                    v.status = ST_FULL;
                end else begin
                    slot_filter[slot] = addr;
                    slot_live[slot]   = 1'b1;
                end
            end
            OP_REMOVE: begin
                // Only the lowest live copy of an equal filter is freed.
                for (int i = high_water - 1; i >= 0; i--) begin
                    if (slot_live[i] && slot_filter[i] == addr) begin
                        slot = i;
                    end
                end
                if (slot < 0) begin
                    v.status = ST_NOT_FOUND;
                end else begin
                    slot_live[slot] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
        end
    endtask

    // Request driver: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        command_t next_cmd;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            // An accepted transaction updates the table copy at once.
            if (req_if.valid && req_if.ready) begin
                verdict_q.push_back(apply_command(req_if.opcode, req_if.address));
            end
            if (!req_if.valid || req_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end else if (command_q.size() != 0) begin
                    next_cmd = command_q.pop_front();
                    req_if.valid   <= 1'b1;
                    req_if.opcode  <= next_cmd.op;
                    req_if.address <= next_cmd.addr;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: checks each transaction and stalls on its own pattern.
    int          stall_step = 0;
    logic [31:0] ready_pattern = '1;

    always @(posedge i_clk) begin
        verdict_t want;
        if (!i_rst_n) begin
            resp_if.ready <= 1'b0;
        end else begin
            if (resp_if.valid && resp_if.ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("response with no command outstanding");
                end else begin
                    want = verdict_q.pop_front();
                    if (resp_if.rejected !== want.rejected) begin
                        report_mismatch($sformatf("rejected %b, expected %b",
                                                  resp_if.rejected, want.rejected));
                    end
                    if (resp_if.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  resp_if.status, want.status));
                    end
                end
            end
            // A fresh stall pattern each time the step counter wraps, sometimes none at all.
            if (stall_step == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pattern = '1;
                    1: ready_pattern = $urandom;
                    2: ready_pattern = $urandom | $urandom;
                    default: ready_pattern = 32'hFFFF_0000;
                endcase
            end
            resp_if.ready <= ready_pattern[stall_step % 32];
            stall_step = (stall_step + 1) % 64;
        end
    end

    // Random filter: each octet is a wildcard, a small value, 255 or anything.
    function automatic logic [ADDR_W-1:0] random_filter();
        logic [ADDR_W-1:0] f;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 5))
                0, 1: f[8*k +: 8] = 8'd0;
                2, 3: f[8*k +: 8] = 8'($urandom_range(1, 3));
                4: f[8*k +: 8] = 8'hFF;
                default: f[8*k +: 8] = 8'($urandom_range(1, 255));
            endcase
        end
        return f;
    endfunction

    task automatic push_command(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
        command_t c;
        c.op   = op;
        c.addr = addr;
        command_q.push_back(c);
    endtask

    // Queue a phase of random commands with the given add and remove weights.
    task automatic queue_random(input int count, input int add_w, input int remove_w);
        int                r;
        int                idx;
        logic [ADDR_W-1:0] a;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
                push_command(OP_SPARE, $urandom);
            end else if (r < 2 + add_w) begin
                if (filter_pool.size() != 0 && $urandom_range(0, 4) == 0) begin
                    a = filter_pool[$urandom_range(0, filter_pool.size() - 1)];
                end else begin
                    a = random_filter();
                end
                filter_pool.push_back(a);
                if (filter_pool.size() > 128) begin
                    void'(filter_pool.pop_front());
                end
                push_command(OP_ADD, a);
            end else if (r < 2 + add_w + remove_w) begin
                if (filter_pool.size() != 0 && $urandom_range(0, 3) != 0) begin
                    idx = $urandom_range(0, filter_pool.size() - 1);
                    a = filter_pool[idx];
                    filter_pool.delete(idx);
                end else begin
                    a = random_filter();
                end
                push_command(OP_REMOVE, a);
            end else begin
                // Half the checks are aimed at a stored filter, when the pool holds one.
                if (filter_pool.size() != 0 && $urandom_range(0, 1) == 0) begin
                    a = filter_pool[$urandom_range(0, filter_pool.size() - 1)];
                    a = a | ($urandom & ~wildcard_mask(a));
                end else if ($urandom_range(0, 1) == 0) begin
                    for (int k = 0; k < 4; k++) begin
                        a[8*k +: 8] = ($urandom_range(0, 5) < 3) ?
                                      8'($urandom_range(1, 3)) : 8'($urandom);
                    end
                end else begin
                    a = $urandom;
                end
                push_command(OP_CHECK, a);
            end
        end
    endtask

    // Wait until every command has been sent and every response has arrived.
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (command_q.size() != 0 || req_if.valid || verdict_q.size() != 0);
    endtask

    // Drain, let the chain settle, then write ban_mode in one transaction.
    task automatic write_ban_mode(input logic value);
        wait_drained();
        repeat (TABLE_DEPTH + 4) @(posedge i_clk);
        cfg_if.valid    <= 1'b1;
        cfg_if.ban_mode <= value;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        ban_mode_copy = value;
        cfg_if.valid <= 1'b0;
    endtask

    // Stimulus and end of run.
    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            slot_live[i]   = 1'b0;
            slot_filter[i] = '0;
        end
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.opcode   = OP_CHECK;
        req_if.address  = '0;
        resp_if.ready   = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.ban_mode = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, spare opcode, all-ones and all-zero filters,
        // duplicates, slot reuse and remove misses, all in ban mode.
        push_command(OP_CHECK,  32'h0000_0000);
        push_command(OP_CHECK,  32'hFFFF_FFFF);
        push_command(OP_REMOVE, 32'h0000_000A);
        push_command(OP_SPARE,  32'hFFFF_FFFF);
        push_command(OP_SPARE,  32'h0000_0000);
        push_command(OP_ADD,    32'hFFFF_FFFF);
        push_command(OP_CHECK,  32'hFFFF_FFFF);
        push_command(OP_CHECK,  32'h7FFF_FFFF);
        push_command(OP_ADD,    32'h0000_000A);
        push_command(OP_ADD,    32'h0000_000A);
        push_command(OP_CHECK,  32'h0403_020A);
        push_command(OP_REMOVE, 32'h0000_000A);
        push_command(OP_CHECK,  32'h0403_020A);
        push_command(OP_ADD,    32'h0101_A8C0);
        push_command(OP_REMOVE, 32'h0000_000A);
        push_command(OP_REMOVE, 32'h0000_000A);
        push_command(OP_CHECK,  32'h0000_000B);
        push_command(OP_ADD,    32'h0000_0000);
        push_command(OP_CHECK,  32'h1234_5678);
        push_command(OP_REMOVE, 32'h0000_0000);
        push_command(OP_REMOVE, 32'hFFFF_FFFF);
        push_command(OP_CHECK,  32'h0101_A8C0);
        push_command(OP_REMOVE, 32'h0101_A8C0);

        // Add-heavy phase fills the table until adds report full.
        queue_random(350, 60, 10);
        write_ban_mode(1'b0);
        queue_random(400, 30, 25);
        write_ban_mode(1'b1);
        // Remove-heavy phase drains the table towards empty.
        queue_random(300, 10, 55);
        write_ban_mode(1'b0);
        queue_random(350, 55, 15);
        write_ban_mode(1'b1);
        queue_random(300, 30, 30);

        wait_drained();
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
